[sv/deque_min_max_extract_unit_assert.svh]
// assertion macros for the deque min/max extract unit
// used by the top level; needs nothing but a clock and an active-low reset
`ifndef DEQUE_MIN_MAX_EXTRACT_UNIT_ASSERT_SVH
`define DEQUE_MIN_MAX_EXTRACT_UNIT_ASSERT_SVH

// property that must hold at every edge out of reset
`define DMME_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define DMME_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[sv/dmme_pkg.sv]
// shared types and constants for the deque min/max extract unit
// no dependencies
`default_nettype none

package dmme_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int FUNC_W      = 3;
  localparam int STAT_W      = 2;
  localparam int CNT_OUT_W   = 5;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND       = 3'd0,
    FN_PUSH_FRONT   = 3'd1,
    FN_REMOVE_FIRST = 3'd2,
    FN_REMOVE_LAST  = 3'd3,
    FN_REMOVE_MIN   = 3'd4,
    FN_REMOVE_MAX   = 3'd5,
    FN_EMPTY        = 3'd6
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_PUSH,
    CELL_POP_FRONT,
    CELL_POP_BACK,
    CELL_EXTRACT,
    CELL_CLEAR
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } state_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    cell_op_t op;
    logic     scan_en;
    logic     start;
    logic     want_max;
  } cell_cmd_t;

endpackage

`default_nettype wire

[sv/dmme_cell.sv]
// one storage cell of the deque chain: holds a key/value entry and its search state
// depends on dmme_pkg
`default_nettype none

module dmme_cell
  import dmme_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cell_cmd_t        cmd,
  input  wire logic             first_i,
  input  wire logic             improve_any,
  input  wire logic [KEY_W-1:0] ins_key,
  input  wire logic [VAL_W-1:0] ins_val,
  input  wire logic [KEY_W-1:0] left_key,
  input  wire logic [VAL_W-1:0] left_val,
  input  wire logic             left_vld,
  input  wire logic             left_ge,
  input  wire logic [KEY_W-1:0] right_key,
  input  wire logic [VAL_W-1:0] right_val,
  input  wire logic             right_vld,
  input  wire logic             tok_in,
  input  wire logic [KEY_W-1:0] best_in,
  output logic      [KEY_W-1:0] key_o,
  output logic      [VAL_W-1:0] val_o,
  output logic                  vld_o,
  output logic                  ge_o,
  output logic                  tok_o,
  output logic      [KEY_W-1:0] best_o,
  output logic                  improve_o,
  output logic                  taken_o,
  output logic      [KEY_W-1:0] take_key_o,
  output logic      [VAL_W-1:0] take_val_o
);

  logic [KEY_W-1:0] key_r, key_nxt, best_r, best_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic             vld_r, vld_nxt, ge_r, ge_nxt, tok_r, tok_nxt;
  logic             hit, better, taken;

  always_comb begin
    hit = tok_in & vld_r & cmd.scan_en;
    if (first_i) begin
      better = 1'b1;
    end else if (cmd.want_max) begin
      better = $signed(key_r) > $signed(best_in);
    end else begin
      better = $signed(key_r) < $signed(best_in);
    end
    tok_nxt  = hit;
    best_nxt = better ? key_r : best_in;
    // a later improvement moves the removal point past this cell
    if (hit) begin
      ge_nxt = 1'b1;
    end else if (improve_any) begin
      ge_nxt = 1'b0;
    end else begin
      ge_nxt = ge_r;
    end
  end

  always_comb begin
    key_nxt = key_r;
    val_nxt = val_r;
    vld_nxt = vld_r;
    taken   = 1'b0;
    case (cmd.op)
      CELL_APPEND: begin
        if (!vld_r && left_vld) begin
          key_nxt = ins_key;
          val_nxt = ins_val;
          vld_nxt = 1'b1;
        end
      end
      CELL_PUSH: begin
        key_nxt = left_key;
        val_nxt = left_val;
        vld_nxt = left_vld;
      end
      CELL_POP_FRONT: begin
        taken   = first_i & vld_r;
        key_nxt = right_key;
        val_nxt = right_val;
        vld_nxt = right_vld;
      end
      CELL_POP_BACK: begin
        taken   = vld_r & ~right_vld;
        vld_nxt = vld_r & right_vld;
      end
      CELL_EXTRACT: begin
        taken = vld_r & ge_r & ~left_ge;
        if (ge_r) begin
          key_nxt = right_key;
          val_nxt = right_val;
          vld_nxt = right_vld;
        end
      end
      CELL_CLEAR: vld_nxt = 1'b0;
      default:    vld_nxt = vld_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      tok_r <= 1'b0;
      ge_r  <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      tok_r <= tok_nxt;
      ge_r  <= ge_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    val_r  <= val_nxt;
    best_r <= best_nxt;
  end

  assign key_o      = key_r;
  assign val_o      = val_r;
  assign vld_o      = vld_r;
  assign ge_o       = ge_r;
  assign tok_o      = tok_r;
  assign best_o     = best_r;
  assign improve_o  = hit & better;
  assign taken_o    = taken;
  assign take_key_o = taken ? key_r : '0;
  assign take_val_o = taken ? val_r : '0;

endmodule

`default_nettype wire

[sv/dmme_ctrl.sv]
// request sequencer, entry count and result register of the deque unit
// depends on dmme_pkg
`default_nettype none

module dmme_ctrl
  import dmme_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [FUNC_W-1:0]      in_tuser,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [STAT_W-1:0]      out_tuser,
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  input  wire logic [KEY_W-1:0]       take_key,
  input  wire logic [VAL_W-1:0]       take_val,
  output cell_cmd_t                   cmd,
  output logic      [KEY_W-1:0]       ins_key,
  output logic      [VAL_W-1:0]       ins_val,
  output logic [$clog2(DEPTH+1)-1:0]  cnt_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  state_t           state_r, state_nxt;
  func_t            func_r;
  logic [KEY_W-1:0] key_r, out_key_r;
  logic [VAL_W-1:0] val_r, out_val_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [IW-1:0]    scan_idx_r;
  logic             out_valid_r, out_free, exec_fire, in_fire, full, empty, scan_last;
  status_t          status, out_status_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;
  func_t            in_func;

  assign in_func   = func_t'(in_tuser);
  assign in_fire   = in_tvalid & in_tready;
  assign out_free  = ~out_valid_r | out_tready;
  assign full      = cnt_r >= CW'(DEPTH);
  assign empty     = cnt_r == '0;
  assign scan_last = scan_idx_r == IW'(cnt_r - CW'(1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if ((in_func == FN_REMOVE_MIN || in_func == FN_REMOVE_MAX) && !empty) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_SCAN: if (scan_last) state_nxt = S_EXEC;
      S_EXEC: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready    = (state_r == S_IDLE);
    cmd.op       = CELL_HOLD;
    cmd.scan_en  = 1'b0;
    cmd.start    = 1'b0;
    cmd.want_max = (func_r == FN_REMOVE_MAX);
    exec_fire    = 1'b0;
    status       = ST_OK;
    cnt_nxt      = cnt_r;
    case (state_r)
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        cmd.start   = (scan_idx_r == '0);
      end
      S_EXEC: begin
        if (out_free) begin
          exec_fire = 1'b1;
          case (func_r) inside
            FN_APPEND, FN_PUSH_FRONT: begin
              if (full) begin
                status = ST_FULL;
              end else begin
                cmd.op  = (func_r == FN_APPEND) ? CELL_APPEND : CELL_PUSH;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            FN_REMOVE_FIRST, FN_REMOVE_LAST, FN_REMOVE_MIN, FN_REMOVE_MAX: begin
              if (empty) begin
                status = ST_EMPTY;
              end else begin
                cnt_nxt = cnt_r - CW'(1);
                case (func_r)
                  FN_REMOVE_FIRST: cmd.op = CELL_POP_FRONT;
                  FN_REMOVE_LAST:  cmd.op = CELL_POP_BACK;
                  default:         cmd.op = CELL_EXTRACT;
                endcase
              end
            end
            FN_EMPTY: begin
              cmd.op  = CELL_CLEAR;
              cnt_nxt = '0;
            end
            default: cnt_nxt = cnt_r;
          endcase
        end
      end
      default: cmd.op = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      scan_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec_fire) cnt_r <= cnt_nxt;
      if (in_fire) begin
        scan_idx_r <= '0;
      end else if (state_r == S_SCAN) begin
        scan_idx_r <= scan_idx_r + IW'(1);
      end
      if (exec_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r <= in_func;
      key_r  <= in_tdata[KEY_W-1:0];
      val_r  <= in_tdata[KEY_W+VAL_W-1:KEY_W];
    end
    if (exec_fire) begin
      out_status_r <= status;
      out_key_r    <= take_key;
      out_val_r    <= take_val;
      out_cnt_r    <= CNT_OUT_W'(cnt_nxt);
    end
  end

  assign ins_key    = key_r;
  assign ins_val    = val_r;
  assign cnt_o      = cnt_r;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {(OUT_TDATA_W - CNT_OUT_W - VAL_W - KEY_W)'(0),
                       out_cnt_r, out_val_r, out_key_r};

endmodule

`default_nettype wire

[sv/deque_min_max_extract_unit.sv]
// top level of the deque min/max extract unit: controller plus a chain of entry cells
// depends on dmme_pkg, dmme_cell, dmme_ctrl and deque_min_max_extract_unit_assert.svh
`default_nettype none

// Bounded double-ended queue of up to DEPTH signed-key/value entries, packed in
// insertion order with the front in cell 0. Each input word is one request
// (append, push front, remove first, remove last, remove smallest key, remove
// largest key, empty) and yields exactly one result word carrying status, the
// removed key/value (zero when nothing is removed) and the entry count after
// the request. Ties on min/max removal pick the entry nearest the front.
// Sequence: a request is accepted in the idle state and executed in the exec
// state; insert, front/back removal and empty go there directly. Min/max
// removal on a non-empty store first scans, and a search token walks the
// cell chain one cell per clock, carrying the best key so far, and every cell
// remembers whether it lies at or after the current best; the removal then
// closes the gap in a single shift. A finished result sits in the output
// register while the next word is accepted; execution waits only if that
// register is still full.

`include "deque_min_max_extract_unit_assert.svh"

module deque_min_max_extract_unit
  import dmme_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [FUNC_W-1:0]      in_tuser,   // [2:0] func
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] in_key, [63:32] in_value
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [STAT_W-1:0]      out_tuser,  // [1:0] status
  output logic      [OUT_TDATA_W-1:0] out_tdata   // [31:0] out_key, [63:32] out_value,
                                                  // [68:64] count, rest zero
);

  localparam int CW = $clog2(DEPTH + 1);

  cell_cmd_t        cmd;
  logic [KEY_W-1:0] ins_key, take_key;
  logic [VAL_W-1:0] ins_val, take_val;
  logic [CW-1:0]    cnt;

  // per-cell outputs
  logic [KEY_W-1:0] key_w      [DEPTH];
  logic [VAL_W-1:0] val_w      [DEPTH];
  logic [KEY_W-1:0] best_w     [DEPTH];
  logic [KEY_W-1:0] take_key_w [DEPTH];
  logic [VAL_W-1:0] take_val_w [DEPTH];
  logic [DEPTH-1:0] vld_vec, ge_vec, tok_vec, improve_vec, take_vec;

  // neighbor wiring into each cell
  logic [KEY_W-1:0] lkey [DEPTH];
  logic [VAL_W-1:0] lval [DEPTH];
  logic [KEY_W-1:0] rkey [DEPTH];
  logic [VAL_W-1:0] rval [DEPTH];
  logic [KEY_W-1:0] bin  [DEPTH];
  logic [DEPTH-1:0] lvld, lge, rvld, tin, first_vec;
  logic             improve_any;

  dmme_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .take_key   (take_key),
    .take_val   (take_val),
    .cmd        (cmd),
    .ins_key    (ins_key),
    .ins_val    (ins_val),
    .cnt_o      (cnt)
  );

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      // the head cell sees the incoming word on its left for push front
      if (i == 0) begin
        lkey[i]      = ins_key;
        lval[i]      = ins_val;
        lvld[i]      = 1'b1;
        lge[i]       = 1'b0;
        tin[i]       = cmd.start;
        bin[i]       = '0;
        first_vec[i] = 1'b1;
      end else begin
        lkey[i]      = key_w[i-1];
        lval[i]      = val_w[i-1];
        lvld[i]      = vld_vec[i-1];
        lge[i]       = ge_vec[i-1];
        tin[i]       = tok_vec[i-1];
        bin[i]       = best_w[i-1];
        first_vec[i] = 1'b0;
      end
      // tail cell shifts in an empty slot
      if (i == DEPTH - 1) begin
        rkey[i] = '0;
        rval[i] = '0;
        rvld[i] = 1'b0;
      end else begin
        rkey[i] = key_w[i+1];
        rval[i] = val_w[i+1];
        rvld[i] = vld_vec[i+1];
      end
    end
  end

  // only the cell holding the search token can raise an improvement
  assign improve_any = |improve_vec;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    dmme_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .first_i     (first_vec[g]),
      .improve_any (improve_any),
      .ins_key     (ins_key),
      .ins_val     (ins_val),
      .left_key    (lkey[g]),
      .left_val    (lval[g]),
      .left_vld    (lvld[g]),
      .left_ge     (lge[g]),
      .right_key   (rkey[g]),
      .right_val   (rval[g]),
      .right_vld   (rvld[g]),
      .tok_in      (tin[g]),
      .best_in     (bin[g]),
      .key_o       (key_w[g]),
      .val_o       (val_w[g]),
      .vld_o       (vld_vec[g]),
      .ge_o        (ge_vec[g]),
      .tok_o       (tok_vec[g]),
      .best_o      (best_w[g]),
      .improve_o   (improve_vec[g]),
      .taken_o     (take_vec[g]),
      .take_key_o  (take_key_w[g]),
      .take_val_o  (take_val_w[g])
    );
  end

  // at most one cell gates out its entry, so an or-merge picks it
  always_comb begin
    take_key = '0;
    take_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      take_key = take_key | take_key_w[i];
      take_val = take_val | take_val_w[i];
    end
  end

  // occupied cells always form one run starting at the head
  `DMME_ASSERT_ALWAYS(a_packed_run, clk, rst_n, ((vld_vec >> 1) & ~vld_vec) == '0,
                      "entry cells not packed toward the head")
  // controller count tracks the occupied cells
  `DMME_ASSERT_ALWAYS(a_count_match, clk, rst_n, $countones(vld_vec) == cnt,
                      "entry count differs from occupied cells")
  // min/max removal takes exactly one cell
  `DMME_ASSERT_IMPLY(a_extract_onehot, clk, rst_n, cmd.op == CELL_EXTRACT, $onehot(take_vec),
                     "min/max removal point not unique")

endmodule

`default_nettype wire

[test/tb_deque_min_max_extract_unit.sv]
// self-checking testbench for deque_min_max_extract_unit: directed and random request streams
// depends on dmme_pkg and the unit's rtl; an internal shadow deque predicts every result word

module tb_deque_min_max_extract_unit
  import dmme_pkg::*;
();

  // the selector value that the unit must ignore
  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
  localparam int RAND_ITEMS = 1250;
  localparam int CYCLE_LIMIT = 500000;
  // worst min/max search on a full store plus margin
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    logic [FUNC_W-1:0] fn;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  val;
    bit                drain_first;  // hold off until every result has come back
  } request_t;

  typedef struct {
    logic signed [KEY_W-1:0] key;
    logic [VAL_W-1:0]        val;
  } entry_t;

  typedef struct {
    logic [STAT_W-1:0]    status;
    logic [KEY_W-1:0]     key;
    logic [VAL_W-1:0]     val;
    logic [CNT_OUT_W-1:0] count;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [FUNC_W-1:0] in_tuser = '0;      // [2:0] func
  logic [IN_TDATA_W-1:0] in_tdata = '0;  // [31:0] in_key, [63:32] in_value
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [STAT_W-1:0] out_tuser;          // [1:0] status
  logic [OUT_TDATA_W-1:0] out_tdata;     // [31:0] out_key, [63:32] out_value, [68:64] count

  request_t pending[$];      // requests not yet put on the bus
  entry_t   shadow_deque[$]; // predicted store contents, front at index 0
  result_t  result_q[$];     // predicted result words, oldest first

  int  err_count = 0;
  int  n_accepted = 0;
  int  n_results = 0;
  int  n_full = 0;
  int  n_empty = 0;
  int  n_extract = 0;
  int  cycles = 0;
  int  gen_items = 0;
  bit  sync_next = 1'b0;
  logic in_taken = 1'b0;

  deque_min_max_extract_unit #(
    .DEPTH(DEPTH_DEF)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // apply one request to the shadow deque and return the word the unit should send
  function automatic result_t apply_request(logic [FUNC_W-1:0] fn, logic [KEY_W-1:0] key,
                                            logic [VAL_W-1:0] val);
    result_t r;
    entry_t e;
    int pos;
    r.status = ST_OK;
    r.key = '0;
    r.val = '0;
    e.key = key;
    e.val = val;
    pos = 0;
    case (fn)
      FN_APPEND, FN_PUSH_FRONT: begin
        if (shadow_deque.size() >= DEPTH_DEF) begin
          r.status = ST_FULL;
        end else if (fn == FN_APPEND) begin
          shadow_deque.push_back(e);
        end else begin
          shadow_deque.push_front(e);
        end
      end
      FN_REMOVE_FIRST, FN_REMOVE_LAST, FN_REMOVE_MIN, FN_REMOVE_MAX: begin
        if (shadow_deque.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (fn == FN_REMOVE_LAST) pos = shadow_deque.size() - 1;
          // strict compare keeps the entry nearest the front on a tie
          if (fn == FN_REMOVE_MIN || fn == FN_REMOVE_MAX) begin
            for (int i = 1; i < shadow_deque.size(); i++) begin
              if (fn == FN_REMOVE_MAX ? (shadow_deque[i].key > shadow_deque[pos].key)
                                      : (shadow_deque[i].key < shadow_deque[pos].key))
                pos = i;
            end
          end
          r.key = shadow_deque[pos].key;
          r.val = shadow_deque[pos].val;
          shadow_deque.delete(pos);
        end
      end
      FN_EMPTY: shadow_deque.delete();
      default: ;  // unused selector changes nothing
    endcase
    r.count = CNT_OUT_W'(shadow_deque.size());
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at word %0d: %s got %h expected %h", n_results, what, got, want);
    err_count++;
  endtask

  task automatic add_req(input logic [FUNC_W-1:0] fn, input logic [KEY_W-1:0] key,
                         input logic [VAL_W-1:0] val);
    request_t q;
    q.fn = fn;
    q.key = key;
    q.val = val;
    q.drain_first = sync_next;
    sync_next = 1'b0;
    pending.push_back(q);
    if (fn != FN_UNUSED) gen_items++;
  endtask

  // keys lean toward the extremes and a narrow band so ties happen often
  function automatic logic [KEY_W-1:0] rand_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(0, 7))
      0: k = 32'h8000_0000;
      1: k = 32'h7fff_ffff;
      2, 3: begin
        k = $urandom_range(0, 6);
        k = k - 32'd3;
      end
      default: k = $urandom;
    endcase
    return k;
  endfunction

  function automatic logic [VAL_W-1:0] rand_val();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [FUNC_W-1:0] rand_insert();
    return $urandom_range(0, 1) ? FN_APPEND : FN_PUSH_FRONT;
  endfunction

  function automatic logic [FUNC_W-1:0] rand_removal();
    logic [FUNC_W-1:0] f;
    case ($urandom_range(0, 5))
      0: f = FN_REMOVE_FIRST;
      1: f = FN_REMOVE_LAST;
      2, 3: f = FN_REMOVE_MIN;
      default: f = FN_REMOVE_MAX;
    endcase
    return f;
  endfunction

  // monitor: both handshakes sampled at the rising edge, prediction on input accept
  always @(posedge clk) begin : monitor
    result_t want;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        result_q.push_back(apply_request(in_tuser, in_tdata[31:0], in_tdata[63:32]));
        n_accepted++;
      end
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          report_mismatch("word with nothing expected, key", out_tdata[31:0], '0);
        end else begin
          want = result_q.pop_front();
          if (out_tuser != want.status)
            report_mismatch("status", 32'(out_tuser), 32'(want.status));
          if (out_tdata[31:0] != want.key) report_mismatch("key", out_tdata[31:0], want.key);
          if (out_tdata[63:32] != want.val) report_mismatch("value", out_tdata[63:32], want.val);
          if (out_tdata[68:64] != want.count)
            report_mismatch("count", 32'(out_tdata[68:64]), 32'(want.count));
          if (out_tdata[71:69] != '0) report_mismatch("pad bits", 32'(out_tdata[71:69]), '0);
          if (want.status == ST_FULL) n_full++;
          if (want.status == ST_EMPTY) n_empty++;
        end
        n_results++;
      end
    end
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, result_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // driver: bursts of back-to-back words separated by random gaps
  int burst_left = 8;
  int gap_left = 0;

  always @(negedge clk) begin : driver
    logic nv;
    request_t q;
    if (rst_n) begin
      // a word still waiting for tready stays on the bus untouched
      nv = in_tvalid && !in_taken;
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() != 0 &&
                     !(pending[0].drain_first && result_q.size() != 0)) begin
          q = pending.pop_front();
          in_tuser <= q.fn;
          in_tdata <= {q.val, q.key};
          if (q.fn == FN_REMOVE_MIN || q.fn == FN_REMOVE_MAX) n_extract++;
          nv = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            // some gaps are zero so long runs go through unbroken
            gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
          end
        end
      end
      in_tvalid <= nv;
    end
  end

  // receiver: the stall pattern switches to a randomly chosen mode at random intervals
  int rx_mode = 0;
  int rx_left = 200;
  int rx_phase = 0;

  always @(negedge clk) begin : receiver
    logic rdy;
    rdy = 1'b1;
    rx_phase++;
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(64, 300);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0: rdy = 1'b1;                            // always ready
      1: rdy = 1'($urandom_range(0, 1));        // coin flip
      2: rdy = (rx_phase % 4) == 0;             // one in four
      default: rdy = $urandom_range(0, 9) == 0; // long stalls
    endcase
    out_tready <= rdy;
  end

  initial begin : stimulus
    int kind;
    int n;
    // directed: empty-store removals, ignored selector, key extremes, ties
    add_req(FN_REMOVE_FIRST, 32'h1234_5678, 32'h9abc_def0);
    add_req(FN_REMOVE_LAST, '0, '0);
    add_req(FN_REMOVE_MIN, '0, '0);
    add_req(FN_REMOVE_MAX, '1, '1);
    add_req(FN_EMPTY, '0, '0);
    add_req(FN_UNUSED, '1, '1);
    add_req(FN_APPEND, 32'h8000_0000, '0);
    add_req(FN_APPEND, 32'h7fff_ffff, '1);
    add_req(FN_PUSH_FRONT, '0, 32'ha5a5_a5a5);
    add_req(FN_PUSH_FRONT, '1, 32'h5a5a_5a5a);
    add_req(FN_APPEND, 32'h7fff_ffff, 32'd1);  // ties with the largest key
    add_req(FN_APPEND, 32'h8000_0000, 32'd2);  // ties with the smallest key
    add_req(FN_UNUSED, '0, '0);
    add_req(FN_REMOVE_MAX, '0, '0);
    add_req(FN_REMOVE_MIN, '0, '0);
    add_req(FN_REMOVE_FIRST, '0, '0);
    add_req(FN_REMOVE_LAST, '0, '0);
    add_req(FN_APPEND, 32'd3, 32'd3);
    add_req(FN_EMPTY, '0, '0);
    add_req(FN_REMOVE_LAST, '0, '0);

    // random: fill, drain, tie-heavy and overflow sequences plus some noise
    gen_items = 0;
    sync_next = 1'b1;
    while (gen_items < RAND_ITEMS) begin
      if ($urandom_range(0, 5) == 0) sync_next = 1'b1;
      kind = $urandom_range(0, 9);
      n = $urandom_range(4, 20);
      if (kind < 3) begin
        repeat (n) add_req(rand_insert(), rand_key(), rand_val());
      end else if (kind < 5) begin
        repeat (n) add_req(rand_removal(), rand_key(), rand_val());
      end else if (kind < 7) begin
        // clean store, narrow keys, then searches to exercise front-most tie choice
        add_req(FN_EMPTY, rand_key(), rand_val());
        repeat (n) add_req(rand_insert(), 32'($urandom_range(0, 4)) - 32'd2, rand_val());
        repeat (n) add_req($urandom_range(0, 1) ? FN_REMOVE_MIN : FN_REMOVE_MAX,
                           rand_key(), rand_val());
      end else if (kind < 9) begin
        // overflow the store, then work it back down
        repeat (n + 14) add_req(rand_insert(), rand_key(), rand_val());
        repeat (n) add_req(rand_removal(), rand_key(), rand_val());
      end else begin
        repeat (n) add_req(3'($urandom_range(0, 7)), rand_key(), rand_val());
      end
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_tvalid) @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (result_q.size() != 0) report_mismatch("words never sent", result_q.size(), '0);

    $display("covered %0d requests and %0d result words in %0d cycles", n_accepted,
             n_results, cycles);
    $display("min/max searches %0d, full-store drops %0d, empty-store removals %0d",
             n_extract, n_full, n_empty);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", err_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
